// ===== sv/assert_macros.svh =====
// Assertion helpers used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
// Clocked check that is switched off while reset is asserted.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked check that also holds across reset.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

// ===== sv/swm_pkg.sv =====
package swm_pkg;

  // Build defaults.
  localparam int DATA_WIDTH_DEF = 16;
  localparam int WINDOW_MAX_DEF = 64;

  // Window size register.
  localparam int                CFG_W        = 7;
  localparam logic [CFG_W-1:0] WINDOW_RESET = 7'd1;

  // How far the candidate row moves toward the front when an item is taken.
  typedef enum logic [1:0] {
    SHIFT_NONE,
    SHIFT_ONE,
    SHIFT_TWO
  } shift_t;

  // Control broadcast to every candidate cell.
  typedef struct packed {
    logic   adv;
    logic   clr;
    shift_t shift;
  } cell_ctrl_t;

endpackage

// ===== sv/swm_hist.sv =====
module swm_hist #(
  parameter int WINDOW_MAX = 64,
  parameter int DATA_WIDTH = 16,
  parameter int CNT_W      = 7
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  wr_en,
  input  logic                  clr,
  input  logic [DATA_WIDTH-1:0] wr_data,
  input  logic [CNT_W-1:0]      keff,
  output logic [DATA_WIDTH-1:0] leaving
);

  localparam int PTR_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;

  logic [DATA_WIDTH-1:0] hist_r [0:WINDOW_MAX-1];
  logic [PTR_W-1:0]      ptr_r;
  logic [PTR_W-1:0]      ptr_nxt;
  logic [PTR_W-1:0]      wr_addr;
  logic [PTR_W-1:0]      ptr_after;
  logic [PTR_W-1:0]      rd_addr;
  logic [CNT_W-1:0]      ptr_ext;
  logic [CNT_W-1:0]      rd_ext;
  logic [DATA_WIDTH-1:0] rd_data_r;
  logic [DATA_WIDTH-1:0] byp_data_r;
  logic                  byp_r;

  // A new sequence writes from the start of the buffer.
  always_comb begin
    wr_addr   = clr ? '0 : ptr_r;
    ptr_after = (wr_addr == PTR_W'(WINDOW_MAX - 1)) ? '0 : wr_addr + 1'b1;
    ptr_nxt   = wr_en ? ptr_after : ptr_r;
  end

  // The next item's leaving sample sits keff entries behind the write pointer.
  always_comb begin
    ptr_ext = CNT_W'(ptr_nxt);
    if (ptr_ext >= keff) begin
      rd_ext = ptr_ext - keff;
    end else begin
      rd_ext = ptr_ext + CNT_W'(WINDOW_MAX) - keff;
    end
    rd_addr = rd_ext[PTR_W-1:0];
  end

  // Write pointer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r <= '0;
    end else begin
      ptr_r <= ptr_nxt;
    end
  end

  // History buffer with a registered read that runs one item ahead.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      hist_r[wr_addr] <= wr_data;
    end
    rd_data_r  <= hist_r[rd_addr];
    byp_r      <= wr_en && (rd_addr == wr_addr);
    byp_data_r <= wr_data;
  end

  // A read of the entry written on the same edge takes the new sample.
  assign leaving = byp_r ? byp_data_r : rd_data_r;

endmodule

// ===== sv/swm_cell.sv =====
module swm_cell #(
  parameter int DATA_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  swm_pkg::cell_ctrl_t   ctrl,
  input  logic [DATA_WIDTH-1:0] sample,
  input  logic                  left_keep,
  output logic                  keep,
  output logic [DATA_WIDTH-1:0] post_val,
  output logic                  post_vld,
  input  logic [DATA_WIDTH-1:0] nb1_val,
  input  logic                  nb1_vld,
  input  logic [DATA_WIDTH-1:0] nb2_val,
  input  logic                  nb2_vld,
  output logic [DATA_WIDTH-1:0] q_val,
  output logic                  q_vld
);

  import swm_pkg::*;

  logic [DATA_WIDTH-1:0] q_val_r;
  logic [DATA_WIDTH-1:0] q_val_nxt;
  logic                  q_vld_r;
  logic                  q_vld_nxt;
  logic                  own_vld;

  // A candidate survives the push when it is not smaller than the new sample.
  always_comb begin
    own_vld = q_vld_r && !ctrl.clr;
    keep    = own_vld && ($signed(q_val_r) >= $signed(sample));
  end

  // The new sample lands in the first cell whose candidate was dropped.
  always_comb begin
    if (keep) begin
      post_val = q_val_r;
      post_vld = 1'b1;
    end else begin
      post_val = sample;
      post_vld = left_keep;
    end
  end

  // Front retirements and overflow drops move the row toward the head.
  always_comb begin
    unique case (ctrl.shift)
      SHIFT_NONE: begin
        q_val_nxt = post_val;
        q_vld_nxt = post_vld;
      end
      SHIFT_ONE: begin
        q_val_nxt = nb1_val;
        q_vld_nxt = nb1_vld;
      end
      SHIFT_TWO: begin
        q_val_nxt = nb2_val;
        q_vld_nxt = nb2_vld;
      end
      default: begin
        q_val_nxt = post_val;
        q_vld_nxt = post_vld;
      end
    endcase
  end

  // Cell state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_vld_r <= 1'b0;
    end else if (ctrl.adv) begin
      q_vld_r <= q_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.adv) begin
      q_val_r <= q_val_nxt;
    end
  end

  assign q_val = q_val_r;
  assign q_vld = q_vld_r;

endmodule

// ===== sv/sliding_window_maximum.sv =====
// Sliding window maximum over a stream of signed samples.
// Input channel: in_valid/in_ready carry in_sample and in_start_req. A set
// start flag makes that item the first of a new sequence and empties the
// candidate row; the sample history itself is kept.
// Result channel: out_valid/out_ready carry out_window_max, the largest of the
// last window samples. An item gives a result once window items of its
// sequence have been taken, and none before that.
// Configuration: cfg_wr_en/cfg_wr_data write the window size (0 acts as 1,
// sizes above WINDOW_MAX act as WINDOW_MAX). Input is held off by a registered
// flag after a write while the history read is refetched. Throughput is one
// item per cycle unless that refetch is pending or a result waits on a stalled
// receiver: every candidate cell compares with the new sample in parallel and
// the history memory read is prefetched one item ahead. The result is registered.
// The single output register frees in the cycle it is taken, so a stalled
// receiver blocks input only while a result is still waiting.
// Synchronous reset empties the candidate row, the pointer and the output
// register and sets the window size to one.
module sliding_window_maximum #(
  parameter int WINDOW_MAX = swm_pkg::WINDOW_MAX_DEF,
  parameter int DATA_WIDTH = swm_pkg::DATA_WIDTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [swm_pkg::CFG_W-1:0]  cfg_wr_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [DATA_WIDTH-1:0]      in_sample,
  input  logic                       in_start_req,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [DATA_WIDTH-1:0]      out_window_max
);

  import swm_pkg::*;

`include "assert_macros.svh"

  localparam int NCELL = WINDOW_MAX + 1;
  localparam int CNT_W = (CFG_W > $clog2(WINDOW_MAX + 1)) ? CFG_W : $clog2(WINDOW_MAX + 1);

  logic [CFG_W-1:0]      window_r;
  logic                  cfg_pend_r;
  logic [CNT_W-1:0]      seen_r;
  logic [CNT_W-1:0]      seen_nxt;
  logic [CNT_W-1:0]      seen_base;
  logic [CNT_W-1:0]      keff;
  logic                  out_valid_r;
  logic [DATA_WIDTH-1:0] out_window_max_r;
  logic                  in_acc;
  logic                  had_full;
  logic                  emit;
  logic                  ovf;
  logic                  more;
  logic                  retire;
  logic [DATA_WIDTH-1:0] front_val;
  logic [DATA_WIDTH-1:0] leaving;
  logic [DATA_WIDTH-1:0] result;
  shift_t                shift;
  cell_ctrl_t            ctrl;

  logic [DATA_WIDTH-1:0] p_val [0:NCELL+1];
  logic                  p_vld [0:NCELL+1];
  logic                  keep_chain [0:NCELL];
  logic [DATA_WIDTH-1:0] q_val [0:NCELL-1];
  logic                  q_vld [0:NCELL-1];

  // Handshake.
  assign in_ready = !cfg_pend_r && (!out_valid_r || out_ready);
  assign in_acc   = in_valid && in_ready;

  // Effective window size.
  always_comb begin
    if (window_r == '0) begin
      keff = CNT_W'(1);
    end else if (CNT_W'(window_r) > CNT_W'(WINDOW_MAX)) begin
      keff = CNT_W'(WINDOW_MAX);
    end else begin
      keff = CNT_W'(window_r);
    end
  end

  // Count of samples seen in this sequence, saturating at the window size.
  always_comb begin
    seen_base = in_start_req ? '0 : seen_r;
    had_full  = seen_base >= keff;
    seen_nxt  = had_full ? seen_base : seen_base + 1'b1;
    emit      = seen_nxt >= keff;
  end

  // Sample history.
  swm_hist #(
    .WINDOW_MAX (WINDOW_MAX),
    .DATA_WIDTH (DATA_WIDTH),
    .CNT_W      (CNT_W)
  ) u_hist (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (in_acc),
    .clr     (in_start_req),
    .wr_data (in_sample),
    .keff    (keff),
    .leaving (leaving)
  );

  // Row of candidate cells, front at index zero.
  assign keep_chain[0] = 1'b1;

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    swm_cell #(
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (ctrl),
      .sample    (in_sample),
      .left_keep (keep_chain[i]),
      .keep      (keep_chain[i+1]),
      .post_val  (p_val[i]),
      .post_vld  (p_vld[i]),
      .nb1_val   (p_val[i+1]),
      .nb1_vld   (p_vld[i+1]),
      .nb2_val   (p_val[i+2]),
      .nb2_vld   (p_vld[i+2]),
      .q_val     (q_val[i]),
      .q_vld     (q_vld[i])
    );
  end

  // Past the last cell: the sample overflows there only if every cell is kept.
  assign p_val[NCELL]   = in_sample;
  assign p_vld[NCELL]   = keep_chain[NCELL];
  assign p_val[NCELL+1] = in_sample;
  assign p_vld[NCELL+1] = 1'b0;

  // Front handling: overflow drops the oldest, then the leaving sample retires.
  always_comb begin
    ovf       = keep_chain[NCELL];
    front_val = ovf ? p_val[1] : p_val[0];
    more      = ovf || p_vld[1];
    retire    = had_full && more && (front_val == leaving);
    priority if (ovf && retire) begin
      shift = SHIFT_TWO;
    end else if (ovf || retire) begin
      shift = SHIFT_ONE;
    end else begin
      shift = SHIFT_NONE;
    end
  end

  assign ctrl = '{adv: in_acc, clr: in_start_req, shift: shift};

  // New queue front.
  always_comb begin
    unique case (shift)
      SHIFT_NONE: result = p_val[0];
      SHIFT_ONE:  result = p_val[1];
      SHIFT_TWO:  result = p_val[2];
      default:    result = p_val[0];
    endcase
  end

  // Configuration register and refetch hold-off.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r   <= WINDOW_RESET;
      cfg_pend_r <= 1'b0;
    end else begin
      cfg_pend_r <= cfg_wr_en;
      if (cfg_wr_en) begin
        window_r <= cfg_wr_data;
      end
    end
  end

  // Sequence counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= '0;
    end else if (in_acc) begin
      seen_r <= seen_nxt;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && emit) begin
      out_window_max_r <= result;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_window_max = out_window_max_r;

  // Checks.
  `ASSERT_CLK(a_front_present, clk, rst_n, out_valid_r |-> q_vld[0], "result without a queued candidate")
  `ASSERT_CLK(a_row_ordered, clk, rst_n, q_vld[1] |-> ($signed(q_val[0]) >= $signed(q_val[1])), "candidate row out of order")
  `ASSERT_CLK(a_result_is_front, clk, rst_n, ($past(rst_n) && $past(in_acc && emit)) |-> (out_valid_r && (out_window_max == q_val[0])), "result differs from queue front")
  `ASSERT_CLK(a_cfg_holdoff, clk, rst_n, (rst_n && cfg_wr_en) |=> !in_ready, "item taken before history refetch")
  `ASSERT_ALWAYS(a_reset_clears, clk, !rst_n |=> !out_valid_r, "output valid after reset")

endmodule
